// ----- hdl/bmeu_pkg.sv -----
`timescale 1ns / 1ps

package bmeu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HLEN = 32;

  typedef enum logic [2:0] {
    OP_CLMUL  = 3'd0,
    OP_CLMULH = 3'd1,
    OP_CLMULR = 3'd2,
    OP_ROR    = 3'd3,
    OP_ANDN   = 3'd4,
    OP_GREV   = 3'd5,
    OP_SHFL   = 3'd6,
    OP_UNSHFL = 3'd7
  } bmeu_op_t;

  localparam logic [XLEN-1:0] GREV_M0 = 64'h5555555555555555;
  localparam logic [XLEN-1:0] GREV_M1 = 64'h3333333333333333;
  localparam logic [XLEN-1:0] GREV_M2 = 64'h0F0F0F0F0F0F0F0F;
  localparam logic [XLEN-1:0] GREV_M3 = 64'h00FF00FF00FF00FF;
  localparam logic [XLEN-1:0] GREV_M4 = 64'h0000FFFF0000FFFF;
  localparam logic [XLEN-1:0] GREV_M5 = 64'h00000000FFFFFFFF;

  localparam logic [XLEN-1:0] SHFL_L0 = 64'h4444444444444444;
  localparam logic [XLEN-1:0] SHFL_R0 = 64'h2222222222222222;
  localparam logic [XLEN-1:0] SHFL_L1 = 64'h3030303030303030;
  localparam logic [XLEN-1:0] SHFL_R1 = 64'h0C0C0C0C0C0C0C0C;
  localparam logic [XLEN-1:0] SHFL_L2 = 64'h0F000F000F000F00;
  localparam logic [XLEN-1:0] SHFL_R2 = 64'h00F000F000F000F0;
  localparam logic [XLEN-1:0] SHFL_L3 = 64'h00FF000000FF0000;
  localparam logic [XLEN-1:0] SHFL_R3 = 64'h0000FF000000FF00;
  localparam logic [XLEN-1:0] SHFL_L4 = 64'h0000FFFF00000000;
  localparam logic [XLEN-1:0] SHFL_R4 = 64'h00000000FFFF0000;

  // Swaps each bit group selected by the mask with its neighbor n places up.
  function automatic logic [XLEN-1:0] grev_step(input logic [XLEN-1:0] x,
                                                input logic [XLEN-1:0] m,
                                                input logic [5:0] n);
    grev_step = ((x & m) << n) | ((x & ~m) >> n);
  endfunction

  // Exchanges the inner two quarters of each group defined by the masks.
  function automatic logic [XLEN-1:0] shfl_step(input logic [XLEN-1:0] x,
                                                input logic [XLEN-1:0] ml,
                                                input logic [XLEN-1:0] mr,
                                                input logic [5:0] n);
    shfl_step = (x & ~(ml | mr)) | ((x << n) & ml) | ((x >> n) & mr);
  endfunction

endpackage

// ----- hdl/bmeu_clmul.sv -----
`timescale 1ns / 1ps

module bmeu_clmul (
  input  logic [bmeu_pkg::XLEN-1:0]   op_a,
  input  logic [bmeu_pkg::XLEN-1:0]   op_b,
  output logic [2*bmeu_pkg::XLEN-1:0] product
);

  logic [2*bmeu_pkg::XLEN-1:0] pp [64];
  logic [2*bmeu_pkg::XLEN-1:0] l1 [32];
  logic [2*bmeu_pkg::XLEN-1:0] l2 [16];
  logic [2*bmeu_pkg::XLEN-1:0] l3 [8];
  logic [2*bmeu_pkg::XLEN-1:0] l4 [4];
  logic [2*bmeu_pkg::XLEN-1:0] l5 [2];

  // Partial products are independent; they are folded by a balanced XOR tree.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      pp[i] = op_b[i] ? ({{bmeu_pkg::XLEN{1'b0}}, op_a} << i) : '0;
    end
    for (int i = 0; i < 32; i++) begin
      l1[i] = pp[2*i] ^ pp[2*i+1];
    end
    for (int i = 0; i < 16; i++) begin
      l2[i] = l1[2*i] ^ l1[2*i+1];
    end
    for (int i = 0; i < 8; i++) begin
      l3[i] = l2[2*i] ^ l2[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      l4[i] = l3[2*i] ^ l3[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      l5[i] = l4[2*i] ^ l4[2*i+1];
    end
    product = l5[0] ^ l5[1];
  end

endmodule

// ----- hdl/bmeu_perm.sv -----
`timescale 1ns / 1ps

module bmeu_perm (
  input  bmeu_pkg::bmeu_op_t        op,
  input  logic                      wide,
  input  logic [bmeu_pkg::XLEN-1:0] op_a,
  input  logic [bmeu_pkg::XLEN-1:0] op_b,
  output logic [bmeu_pkg::XLEN-1:0] result
);

  logic [5:0]                     rot_amt;
  logic [2*bmeu_pkg::XLEN-1:0]    rot_wide;
  logic [2*bmeu_pkg::HLEN-1:0]    rot_narrow;
  logic [bmeu_pkg::XLEN-1:0]      ror_res;
  logic [5:0]                     grev_k;
  logic [4:0]                     shfl_k;
  logic [bmeu_pkg::XLEN-1:0]      g0, g1, g2, g3, g4, g5;
  logic [bmeu_pkg::XLEN-1:0]      s4, s3, s2, s1, s0;
  logic [bmeu_pkg::XLEN-1:0]      u0, u1, u2, u3, u4;

  always_comb begin
    rot_amt    = wide ? op_b[5:0] : {1'b0, op_b[4:0]};
    rot_wide   = {op_a, op_a} >> rot_amt;
    rot_narrow = {op_a[bmeu_pkg::HLEN-1:0], op_a[bmeu_pkg::HLEN-1:0]} >> rot_amt[4:0];
    ror_res    = wide ? rot_wide[bmeu_pkg::XLEN-1:0]
                      : {{bmeu_pkg::HLEN{1'b0}}, rot_narrow[bmeu_pkg::HLEN-1:0]};
  end

  always_comb begin
    grev_k = {wide & op_b[5], op_b[4:0]};
    g0 = grev_k[0] ? bmeu_pkg::grev_step(op_a, bmeu_pkg::GREV_M0, 6'd1)  : op_a;
    g1 = grev_k[1] ? bmeu_pkg::grev_step(g0, bmeu_pkg::GREV_M1, 6'd2)    : g0;
    g2 = grev_k[2] ? bmeu_pkg::grev_step(g1, bmeu_pkg::GREV_M2, 6'd4)    : g1;
    g3 = grev_k[3] ? bmeu_pkg::grev_step(g2, bmeu_pkg::GREV_M3, 6'd8)    : g2;
    g4 = grev_k[4] ? bmeu_pkg::grev_step(g3, bmeu_pkg::GREV_M4, 6'd16)   : g3;
    g5 = grev_k[5] ? bmeu_pkg::grev_step(g4, bmeu_pkg::GREV_M5, 6'd32)   : g4;
  end

  always_comb begin
    shfl_k = {wide & op_b[4], op_b[3:0]};
    s4 = shfl_k[4] ? bmeu_pkg::shfl_step(op_a, bmeu_pkg::SHFL_L4, bmeu_pkg::SHFL_R4, 6'd16)
                   : op_a;
    s3 = shfl_k[3] ? bmeu_pkg::shfl_step(s4, bmeu_pkg::SHFL_L3, bmeu_pkg::SHFL_R3, 6'd8) : s4;
    s2 = shfl_k[2] ? bmeu_pkg::shfl_step(s3, bmeu_pkg::SHFL_L2, bmeu_pkg::SHFL_R2, 6'd4) : s3;
    s1 = shfl_k[1] ? bmeu_pkg::shfl_step(s2, bmeu_pkg::SHFL_L1, bmeu_pkg::SHFL_R1, 6'd2) : s2;
    s0 = shfl_k[0] ? bmeu_pkg::shfl_step(s1, bmeu_pkg::SHFL_L0, bmeu_pkg::SHFL_R0, 6'd1) : s1;

    u0 = shfl_k[0] ? bmeu_pkg::shfl_step(op_a, bmeu_pkg::SHFL_L0, bmeu_pkg::SHFL_R0, 6'd1)
                   : op_a;
    u1 = shfl_k[1] ? bmeu_pkg::shfl_step(u0, bmeu_pkg::SHFL_L1, bmeu_pkg::SHFL_R1, 6'd2) : u0;
    u2 = shfl_k[2] ? bmeu_pkg::shfl_step(u1, bmeu_pkg::SHFL_L2, bmeu_pkg::SHFL_R2, 6'd4) : u1;
    u3 = shfl_k[3] ? bmeu_pkg::shfl_step(u2, bmeu_pkg::SHFL_L3, bmeu_pkg::SHFL_R3, 6'd8) : u2;
    u4 = shfl_k[4] ? bmeu_pkg::shfl_step(u3, bmeu_pkg::SHFL_L4, bmeu_pkg::SHFL_R4, 6'd16)
                   : u3;
  end

  always_comb begin
    unique case (op)
      bmeu_pkg::OP_ROR:    result = ror_res;
      bmeu_pkg::OP_ANDN:   result = op_a & ~op_b;
      bmeu_pkg::OP_GREV:   result = g5;
      bmeu_pkg::OP_SHFL:   result = s0;
      bmeu_pkg::OP_UNSHFL: result = u4;
      default:             result = '0;
    endcase
  end

endmodule

// ----- hdl/bitmanip_execute_unit_top.sv -----
`timescale 1ns / 1ps

// Bit-manipulation execute unit: carry-less multiply (low, high, reversed),
// rotate right, and-with-complement, generalized reverse, shuffle and unshuffle.
// A request enters on the in_ channel and is taken at a rising edge where
// in_valid is high and in_stall is low. Its result leaves on the out_ channel
// and is taken at an edge where out_valid is high and out_stall is low.
// Each request passes through an input register, one pass of combinational
// logic (a 64 by 64 carry-less product tree in parallel with the permutation
// network) and a result register, from which the result is shown on the out_
// channel. One request is taken every cycle while out_stall stays low.
// When the receiver stalls, the result register holds its value and the input
// register still takes one more request; in_stall rises only when both are
// full. With in_wide_mode low, only the low operand halves are used and the
// upper half of out_result_value is zero.
// Reset clears both valid flags; the operand and result registers are not reset.

module bitmanip_execute_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic        in_wide_mode,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_value
);

  logic                        in_valid_r;
  logic [2:0]                  req_type_r;
  logic                        wide_r;
  logic [bmeu_pkg::XLEN-1:0]   opa_r;
  logic [bmeu_pkg::XLEN-1:0]   opb_r;
  logic                        out_valid_r;
  logic [bmeu_pkg::XLEN-1:0]   result_r;
  logic [bmeu_pkg::XLEN-1:0]   result_nxt;

  bmeu_pkg::bmeu_op_t          op;
  logic [bmeu_pkg::XLEN-1:0]   opa_m;
  logic [bmeu_pkg::XLEN-1:0]   opb_m;
  logic [2*bmeu_pkg::XLEN-1:0] product;
  logic [bmeu_pkg::XLEN-1:0]   perm_res;
  logic                        out_load;
  logic                        in_take;

  assign out_load = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  assign op    = bmeu_pkg::bmeu_op_t'(req_type_r);
  assign opa_m = wide_r ? opa_r : {{bmeu_pkg::HLEN{1'b0}}, opa_r[bmeu_pkg::HLEN-1:0]};
  assign opb_m = wide_r ? opb_r : {{bmeu_pkg::HLEN{1'b0}}, opb_r[bmeu_pkg::HLEN-1:0]};

  bmeu_clmul u_clmul (
    .op_a    (opa_m),
    .op_b    (opb_m),
    .product (product)
  );

  bmeu_perm u_perm (
    .op     (op),
    .wide   (wide_r),
    .op_a   (opa_m),
    .op_b   (opb_m),
    .result (perm_res)
  );

  always_comb begin
    unique case (op)
      bmeu_pkg::OP_CLMUL:  result_nxt = product[63:0];
      bmeu_pkg::OP_CLMULH: result_nxt = wide_r ? product[127:64]
                                               : {32'b0, product[63:32]};
      bmeu_pkg::OP_CLMULR: result_nxt = wide_r ? product[126:63]
                                               : {32'b0, product[62:31]};
      default:             result_nxt = perm_res;
    endcase
    if (!wide_r) begin
      result_nxt[bmeu_pkg::XLEN-1:bmeu_pkg::HLEN] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_type_r <= in_req_type;
      wide_r     <= in_wide_mode;
      opa_r      <= in_operand_a;
      opb_r      <= in_operand_b;
    end
    if (out_load) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;

endmodule
